@@ design/two_stage_boxcar_ratio_force_assert.svh @@
// Assertion macros shared by the boxcar ratio force design files.
`ifndef TWO_STAGE_BOXCAR_RATIO_FORCE_ASSERT_SVH
`define TWO_STAGE_BOXCAR_RATIO_FORCE_ASSERT_SVH

// Same-cycle implication, checked on clk_i, masked while rst_ni is low.
`define TSBRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsbrf: implication check failed");

// Next-cycle implication, checked on clk_i, masked while rst_ni is low.
`define TSBRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsbrf: next-cycle check failed");

`endif

@@ design/tsbrf_pkg.sv @@
// Shared types and constants of the boxcar ratio force block.
`timescale 1ns / 1ps
package tsbrf_pkg;

  // Field widths of the record layout
  localparam int SUM_W   = 31;
  localparam int SEQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int FORCE_W = 32;
  localparam int SCALE_W = 32;
  localparam int MAG_W   = 31;
  localparam int PROD_W  = 62;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 144;

  // Input tdata layout
  localparam int SAMPLE_A_LSB = 0;
  localparam int SAMPLE_B_LSB = 24;
  localparam int ELAPSED_LSB  = 48;

  // Serial unit step counter widths
  localparam int MUL_CW = $clog2(SCALE_W);
  localparam int DIV_CW = $clog2(PROD_W);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIVISOR = 2'd2;

  // Record kinds
  localparam logic KIND_ADC   = 1'b0;
  localparam logic KIND_FORCE = 1'b1;

  // Snapshot of the decimator after one sample transfer
  typedef struct packed {
    logic             short_done;
    logic             long_done;
    logic [SUM_W-1:0] sa;
    logic [SUM_W-1:0] sb;
    logic [SUM_W-1:0] la;
    logic [SUM_W-1:0] lb;
    logic [SEQ_W-1:0] adc_seq;
    logic [SEQ_W-1:0] frc_seq;
  } tsbrf_event_t;

endpackage

@@ design/tsbrf_accum.sv @@
// Two cascaded boxcar accumulators with window counters and sequence numbers.
`timescale 1ns / 1ps
module tsbrf_accum import tsbrf_pkg::*; #(
  parameter int SHORT_LEN   = 8,
  parameter int LONG_LEN    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [SAMPLE_BITS-1:0] sample_a_i,
  input  logic [SAMPLE_BITS-1:0] sample_b_i,
  output tsbrf_event_t           ev_o
);

  localparam int SCW = $clog2(SHORT_LEN);
  localparam int LCW = $clog2(LONG_LEN);

  logic [SUM_W-1:0] ssa_q, ssb_q, lsa_q, lsb_q;
  logic [SUM_W-1:0] ssa_d, ssb_d, lsa_d, lsb_d;
  logic [SUM_W-1:0] a_ext, b_ext;
  logic [SCW-1:0]   scnt_q;
  logic [LCW-1:0]   lcnt_q;
  logic [SEQ_W-1:0] adc_seq_q, frc_seq_q;
  logic             short_end, long_end;
  tsbrf_event_t     ev_q;

  // Sign-extend samples and form both running sums
  always_comb begin
    a_ext     = {{(SUM_W-SAMPLE_BITS){sample_a_i[SAMPLE_BITS-1]}}, sample_a_i};
    b_ext     = {{(SUM_W-SAMPLE_BITS){sample_b_i[SAMPLE_BITS-1]}}, sample_b_i};
    ssa_d     = ssa_q + a_ext;
    ssb_d     = ssb_q + b_ext;
    lsa_d     = lsa_q + ssa_d;
    lsb_d     = lsb_q + ssb_d;
    short_end = (scnt_q == SCW'(SHORT_LEN - 1));
    long_end  = (lcnt_q == LCW'(LONG_LEN - 1));
  end

  // Advance the windows on each sample transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssa_q     <= '0;
      ssb_q     <= '0;
      lsa_q     <= '0;
      lsb_q     <= '0;
      scnt_q    <= '0;
      lcnt_q    <= '0;
      adc_seq_q <= '0;
      frc_seq_q <= '0;
      ev_q      <= '0;
    end else if (take_i) begin
      ev_q.short_done <= short_end;
      ev_q.long_done  <= short_end && long_end;
      ev_q.sa         <= ssa_d;
      ev_q.sb         <= ssb_d;
      ev_q.la         <= lsa_d;
      ev_q.lb         <= lsb_d;
      ev_q.adc_seq    <= adc_seq_q;
      ev_q.frc_seq    <= frc_seq_q;
      if (short_end) begin
        ssa_q     <= '0;
        ssb_q     <= '0;
        scnt_q    <= '0;
        adc_seq_q <= adc_seq_q + 1'b1;
        if (long_end) begin
          lsa_q     <= '0;
          lsb_q     <= '0;
          lcnt_q    <= '0;
          frc_seq_q <= frc_seq_q + 1'b1;
        end else begin
          lsa_q  <= lsa_d;
          lsb_q  <= lsb_d;
          lcnt_q <= lcnt_q + 1'b1;
        end
      end else begin
        ssa_q  <= ssa_d;
        ssb_q  <= ssb_d;
        scnt_q <= scnt_q + 1'b1;
      end
    end
  end

  assign ev_o = ev_q;

endmodule

@@ design/tsbrf_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module tsbrf_mul import tsbrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MAG_W-1:0]  mcand_i,
  input  logic [SCALE_W-1:0] mplier_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  logic [MAG_W+SCALE_W-1:0] p_q, p_d;
  logic [MAG_W-1:0]         mcand_q;
  logic [MAG_W:0]           upper_sum;
  logic [MUL_CW-1:0]        cnt_q;
  logic                     busy_q, done_q;

  // Add the multiplicand into the upper half when the low bit is set, then shift
  always_comb begin
    upper_sum = {1'b0, p_q[MAG_W+SCALE_W-1 -: MAG_W]} +
                (p_q[0] ? {1'b0, mcand_q} : '0);
    p_d       = {upper_sum, p_q[SCALE_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CW'(SCALE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Product and operand shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q     <= {{MAG_W{1'b0}}, mplier_i};
      mcand_q <= mcand_i;
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q[PROD_W-1:0];

endmodule

@@ design/tsbrf_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tsbrf_div import tsbrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [MAG_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quot_o
);

  logic [PROD_W-1:0] dq_q;
  logic [MAG_W-1:0]  rem_q, rem_d, d_q;
  logic [MAG_W:0]    trial, diff;
  logic              ge;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  // Shift in the next dividend bit and subtract the divisor where it fits
  always_comb begin
    trial = {rem_q, dq_q[PROD_W-1]};
    diff  = trial - {1'b0, d_q};
    ge    = (trial >= {1'b0, d_q});
    rem_d = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[PROD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

@@ design/two_stage_boxcar_ratio_force.sv @@
// Top level: sample intake, record sequencing, force ratio and output register.
//
// Channels: samples enter on s_axis (tdata = sample_a, sample_b, elapsed_ms).
// Records leave on m_axis; tuser is the record kind, tlast marks the final
// record caused by one sample. Configuration is a plain write port.
// A sample that closes a short window passes the DECIDE and ADC states,
// and its ADC record is registered onto m_axis. A force record follows
// the serial multiplier, the serial divider and the FIN and FORCE states
// for handoff, sign, tare and saturation; when the divisor check fails it
// follows straight from the ADC state with no ratio computed. A sample
// that closes no window passes only DECIDE, one that closes only the short
// window also ADC, one that closes the long window also the multiplier and
// divider loops; new samples are taken only in IDLE.
// A sample whose window is still open is taken even while a record waits.
// Reset clears all sums, counters and sequence numbers and loads the
// register defaults (scale 1.0, tare 0, minimum divisor 1000).
// When the receiver stalls, the record holds in the output register and the
// block holds before loading the next one; no record is dropped.
`timescale 1ns / 1ps
module two_stage_boxcar_ratio_force import tsbrf_pkg::*; #(
  parameter int SHORT_LEN   = 8,
  parameter int LONG_LEN    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sample_a[23:0], sample_b[47:24], elapsed_ms[79:48]
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // sequence_res[15:0], sum_a[46:16], sum_b[77:47], time_ms[109:78],
  // force_res[141:110], force_valid[142], zero pad[143]
  output logic [OUT_W-1:0]     m_axis_tdata,
  // record_kind[0]
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCALE_W-1:0]   cfg_data_i
);

  `include "two_stage_boxcar_ratio_force_assert.svh"

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_ADC    = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_FIN    = 7'b0100000,
    ST_FORCE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SCALE_W-1:0] scale_q;
  logic [FORCE_W-1:0] tare_q;
  logic [MAG_W-1:0]   min_div_q;

  tsbrf_event_t       ev;
  logic               take;
  logic [TIME_W-1:0]  time_q;

  logic [MAG_W-1:0]   abs_a, abs_b;
  logic               ratio_ok;
  logic               frc_ok_q, neg_q;
  logic [MAG_W-1:0]   divisor_q;

  logic               mul_start, mul_done, div_start, div_done;
  logic [PROD_W-1:0]  prod, quot;

  logic               q_big;
  logic [33:0]        q_clamp;
  logic [34:0]        q_mag, sq_d, sq_q;
  logic signed [35:0] diff;
  logic [FORCE_W-1:0] force_sat;

  logic               out_free, load_adc, load_frc;
  logic               out_valid_q, kind_q, last_q, ovalid_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [SUM_W-1:0]   osa_q, osb_q;
  logic [TIME_W-1:0]  otime_q;
  logic [FORCE_W-1:0] oforce_q;

  assign take          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_W'(65536);
      tare_q    <= '0;
      min_div_q <= MAG_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORCE_SCALE: scale_q   <= cfg_data_i;
        CFG_TARE_OFFSET: tare_q    <= cfg_data_i;
        CFG_MIN_DIVISOR: min_div_q <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  tsbrf_accum #(
    .SHORT_LEN  (SHORT_LEN),
    .LONG_LEN   (LONG_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .sample_a_i(s_axis_tdata[SAMPLE_A_LSB +: SAMPLE_BITS]),
    .sample_b_i(s_axis_tdata[SAMPLE_B_LSB +: SAMPLE_BITS]),
    .ev_o      (ev)
  );

  // Hold the elapsed time of the sample in work
  always_ff @(posedge clk_i) begin
    if (take) begin
      time_q <= s_axis_tdata[ELAPSED_LSB +: TIME_W];
    end
  end

  // Magnitudes of the long sums and the divisor check
  always_comb begin
    abs_a    = ev.la[SUM_W-1] ? (~ev.la + 1'b1) : ev.la;
    abs_b    = ev.lb[SUM_W-1] ? (~ev.lb + 1'b1) : ev.lb;
    ratio_ok = (abs_b != '0) && (abs_b >= min_div_q);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    load_adc  = 1'b0;
    load_frc  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ev.short_done ? ST_ADC : ST_IDLE;
      end
      ST_ADC: begin
        if (out_free) begin
          load_adc = 1'b1;
          if (!ev.long_done) begin
            state_d = ST_IDLE;
          end else if (ratio_ok) begin
            mul_start = 1'b1;
            state_d   = ST_MUL;
          end else begin
            state_d = ST_FORCE;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_FORCE;
      end
      ST_FORCE: begin
        if (out_free) begin
          load_frc = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      frc_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_adc) frc_ok_q <= ratio_ok;
    end
  end

  // Capture sign and divisor for the ratio
  always_ff @(posedge clk_i) begin
    if (load_adc) begin
      neg_q     <= ev.la[SUM_W-1] ^ ev.lb[SUM_W-1];
      divisor_q <= abs_b;
    end
  end

  tsbrf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (abs_a),
    .mplier_i(scale_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tsbrf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod),
    .divisor_i (divisor_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Clamp the quotient past the saturation range and apply the sign
  always_comb begin
    q_big   = |quot[PROD_W-1:33];
    q_clamp = q_big ? {1'b1, 33'd0} : {1'b0, quot[32:0]};
    q_mag   = {1'b0, q_clamp};
    sq_d    = neg_q ? (~q_mag + 1'b1) : q_mag;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) sq_q <= sq_d;
  end

  // Subtract tare and saturate to 32 bits
  always_comb begin
    diff = $signed({sq_q[34], sq_q}) - $signed({{4{tare_q[FORCE_W-1]}}, tare_q});
    if (diff[35:31] == 5'b00000 || diff[35:31] == 5'b11111) begin
      force_sat = diff[FORCE_W-1:0];
    end else if (!diff[35]) begin
      force_sat = {1'b0, {(FORCE_W-1){1'b1}}};
    end else begin
      force_sat = {1'b1, {(FORCE_W-1){1'b0}}};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_adc || load_frc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_adc) begin
      kind_q   <= KIND_ADC;
      seq_q    <= ev.adc_seq;
      osa_q    <= ev.sa;
      osb_q    <= ev.sb;
      otime_q  <= '0;
      oforce_q <= '0;
      ovalid_q <= 1'b0;
      last_q   <= !ev.long_done;
    end else if (load_frc) begin
      kind_q   <= KIND_FORCE;
      seq_q    <= ev.frc_seq;
      osa_q    <= ev.la;
      osb_q    <= ev.lb;
      otime_q  <= time_q;
      oforce_q <= frc_ok_q ? force_sat : '0;
      ovalid_q <= frc_ok_q;
      last_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {1'b0, ovalid_q, oforce_q, otime_q, osb_q, osa_q, seq_q};

  // Checks
  `TSBRF_ASSERT_IMP(a_no_overwrite, (load_adc || load_frc) && out_valid_q, m_axis_tready)
  `TSBRF_ASSERT_NXT(a_div_follows_mul, mul_done && state_q == ST_MUL, state_q == ST_DIV)
  `TSBRF_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)
  `TSBRF_ASSERT_IMP(a_invalid_force_zero, m_axis_tvalid && !ovalid_q, oforce_q == '0)
  `TSBRF_ASSERT_IMP(a_adc_fields_zero, m_axis_tvalid && m_axis_tuser == KIND_ADC,
                    otime_q == '0 && !ovalid_q)

endmodule
